// File: design/wepl_pkg.sv
// Shared types, widths and constants of the windowed event pair lag block.
package wepl_pkg;

    localparam int TIME_W          = 32;
    localparam int LABEL_W         = 8;
    localparam int LAG_W           = 17;
    localparam int MAX_LAG_W       = 16;
    localparam int S_TDATA_W       = 40;
    localparam int M_TDATA_W       = 40;
    localparam int APB_AW          = 3;
    localparam int APB_DW          = 32;
    localparam int WINDOW_DEPTH_DEF = 32;
    localparam int LABEL_BITS_DEF  = 8;

    localparam logic [MAX_LAG_W-1:0] MAX_LAG_RESET = 16'd1500;

    // Register index of max_lag, taken from the word address.
    localparam logic REG_MAX_LAG = 1'b0;

    // Sequencer states.
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_EVRD  = 9'b000000010,
        S_EVCK  = 9'b000000100,
        S_SCRD  = 9'b000001000,
        S_SCCK  = 9'b000010000,
        S_EMA   = 9'b000100000,
        S_EMB   = 9'b001000000,
        S_FIN   = 9'b010000000,
        S_STORE = 9'b100000000
    } t_state;

    // Result of the shared time difference unit.
    typedef struct packed {
        logic [TIME_W-1:0] diff;
        logic              in_range;
    } t_diff;

endpackage

// File: design/wepl_cfg.sv
// Configuration register file: holds max_lag behind a simple APB-style port.
module wepl_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [wepl_pkg::APB_AW-1:0]   i_paddr,
    input  logic [wepl_pkg::APB_DW-1:0]   i_pwdata,
    output logic [wepl_pkg::APB_DW-1:0]   o_prdata,
    output logic                          o_pready,
    output logic [wepl_pkg::MAX_LAG_W-1:0] o_max_lag
);
    import wepl_pkg::*;

    logic [MAX_LAG_W-1:0] r_max_lag;
    logic                 reg_idx;

    // Byte lanes inside a word are not decoded; bit 2 picks the register.
    assign reg_idx  = i_paddr[2];
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_lag <= MAX_LAG_RESET;
        end else if (i_psel && i_penable && i_pwrite && reg_idx == REG_MAX_LAG) begin
            r_max_lag <= i_pwdata[MAX_LAG_W-1:0];
        end
    end

    always_comb begin
        o_prdata = '0;
        if (reg_idx == REG_MAX_LAG) begin
            o_prdata = APB_DW'(r_max_lag);
        end
    end

    assign o_max_lag = r_max_lag;

endmodule

// File: design/wepl_window.sv
// Event window storage: one write port and one registered read port.
module wepl_window #(
    parameter int DEPTH = wepl_pkg::WINDOW_DEPTH_DEF,
    parameter int LW    = wepl_pkg::LABEL_BITS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [wepl_pkg::TIME_W-1:0] i_wtime,
    input  logic [LW-1:0]               i_wlabel,
    input  logic [AW-1:0]               i_raddr,
    output logic [wepl_pkg::TIME_W-1:0] o_rtime,
    output logic [LW-1:0]               o_rlabel
);
    import wepl_pkg::*;

    logic [TIME_W+LW-1:0] mem [DEPTH];
    logic [TIME_W+LW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= {i_wlabel, i_wtime};
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rtime  = r_rdata[TIME_W-1:0];
    assign o_rlabel = r_rdata[TIME_W+LW-1:TIME_W];

endmodule

// File: design/wepl_diff.sv
// Shared lag unit: modular time difference and the range check against max_lag.
module wepl_diff (
    input  logic [wepl_pkg::TIME_W-1:0]    i_t_new,
    input  logic [wepl_pkg::TIME_W-1:0]    i_t_old,
    input  logic [wepl_pkg::MAX_LAG_W-1:0] i_max_lag,
    output wepl_pkg::t_diff                o_res
);
    import wepl_pkg::*;

    logic [TIME_W-1:0] diff;

    assign diff            = i_t_new - i_t_old;
    assign o_res.diff      = diff;
    assign o_res.in_range  = (diff <= TIME_W'(i_max_lag));

endmodule

// File: design/windowed_event_pair_lags.sv
// Top level of the windowed event pair lag block: sequencer, output register and checks.
// Flow: an event with a label is accepted, then window entries out of range at the old end
// are evicted until one in range is found or the window is empty, every remaining entry is
// scanned, each in-range entry emits a pair and its mirror, the last mirrored beat is flushed
// and the event is stored. The single window read port and the one shared lag unit set the
// pace of this sequence, and a stalled output beat holds it.
// Reset is synchronous and active low; the window contents need no clearing pass.
module windowed_event_pair_lags #(
    parameter int WINDOW_DEPTH = wepl_pkg::WINDOW_DEPTH_DEF,
    parameter int LABEL_BITS   = wepl_pkg::LABEL_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input event stream.
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [wepl_pkg::S_TDATA_W-1:0]  i_s_tdata,   // [31:0] event_time, [39:32] event_label
    // Pair result stream.
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [wepl_pkg::M_TDATA_W-1:0]  o_m_tdata,   // [7:0] first_label, [15:8] second_label,
                                                         // [32:16] lag, [39:33] zero
    output logic                            o_m_tlast,   // last_pair
    output logic                            o_m_tuser,   // pairs_lost
    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wepl_pkg::APB_AW-1:0]     paddr,
    input  logic [wepl_pkg::APB_DW-1:0]     pwdata,
    output logic [wepl_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);
    import wepl_pkg::*;

    // Labels are kept only as wide as both the port and LABEL_BITS allow.
    localparam int LW = (LABEL_BITS < LABEL_W) ? LABEL_BITS : LABEL_W;
    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int SW = AW + 1;

    localparam logic [SW-1:0] DEPTH_S = SW'(WINDOW_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(WINDOW_DEPTH);

    // ---------------------------------------------------------------- configuration
    logic [MAX_LAG_W-1:0] max_lag;

    wepl_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_max_lag (max_lag)
    );

    // ---------------------------------------------------------------- state
    t_state               r_state, n_state;
    logic [TIME_W-1:0]    r_t_new, n_t_new;
    logic [LW-1:0]        r_k_new, n_k_new;
    logic [AW-1:0]        r_head, n_head;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_idx, n_idx;
    logic                 r_ovf, n_ovf;
    // The mirrored half of the latest emitted pair waits here, so that the
    // last beat of an event can be flagged once the scan is known to be done.
    logic                 r_pend, n_pend;
    logic [LW-1:0]        r_pend_lab, n_pend_lab;
    logic [LAG_W-1:0]     r_pend_d, n_pend_d;
    logic [LW-1:0]        r_cand_lab, n_cand_lab;
    logic [LAG_W-1:0]     r_cand_d, n_cand_d;
    // Output register.
    logic                 r_ov, n_ov;
    logic [LABEL_W-1:0]   r_o_first, n_o_first;
    logic [LABEL_W-1:0]   r_o_second, n_o_second;
    logic [LAG_W-1:0]     r_o_lag, n_o_lag;
    logic                 r_o_last, n_o_last;
    logic                 r_o_lost, n_o_lost;

    // ---------------------------------------------------------------- window access
    logic [SW-1:0]        rd_sum, st_sum, hd_sum;
    logic [AW-1:0]        raddr, st_addr, head_inc;
    logic                 we;
    logic [TIME_W-1:0]    rd_time;
    logic [LW-1:0]        rd_lab;
    logic                 full;
    logic [CW-1:0]        idx_inc;
    logic                 scan_done;
    logic                 ofree;
    logic                 s_accept;
    logic [LW-1:0]        in_lab;
    t_diff                dres;

    // The entry under inspection sits idx places after the oldest one.
    assign rd_sum   = SW'(r_head) + SW'(r_idx);
    assign raddr    = (rd_sum >= DEPTH_S) ? AW'(rd_sum - DEPTH_S) : AW'(rd_sum);
    assign st_sum   = SW'(r_head) + SW'(r_count);
    assign st_addr  = full ? r_head
                    : ((st_sum >= DEPTH_S) ? AW'(st_sum - DEPTH_S) : AW'(st_sum));
    assign hd_sum   = SW'(r_head) + SW'(1);
    assign head_inc = (hd_sum >= DEPTH_S) ? AW'(hd_sum - DEPTH_S) : AW'(hd_sum);
    assign full     = (r_count == DEPTH_C);
    assign idx_inc  = r_idx + CW'(1);
    assign scan_done = (idx_inc == r_count);

    wepl_window #(
        .DEPTH (WINDOW_DEPTH),
        .LW    (LW),
        .AW    (AW)
    ) u_window (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (st_addr),
        .i_wtime  (r_t_new),
        .i_wlabel (r_k_new),
        .i_raddr  (raddr),
        .o_rtime  (rd_time),
        .o_rlabel (rd_lab)
    );

    // One subtract-and-compare unit serves both the eviction check and the scan.
    wepl_diff u_diff (
        .i_t_new   (r_t_new),
        .i_t_old   (rd_time),
        .i_max_lag (max_lag),
        .o_res     (dres)
    );

    // ---------------------------------------------------------------- sequencer
    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign in_lab     = i_s_tdata[TIME_W +: LW];
    // The output register can take a new beat when empty or being drained.
    assign ofree      = !r_ov || i_m_tready;

    always_comb begin
        n_state    = r_state;
        n_t_new    = r_t_new;
        n_k_new    = r_k_new;
        n_head     = r_head;
        n_count    = r_count;
        n_idx      = r_idx;
        n_ovf      = r_ovf;
        n_pend     = r_pend;
        n_pend_lab = r_pend_lab;
        n_pend_d   = r_pend_d;
        n_cand_lab = r_cand_lab;
        n_cand_d   = r_cand_d;
        n_ov       = r_ov && !i_m_tready;
        n_o_first  = r_o_first;
        n_o_second = r_o_second;
        n_o_lag    = r_o_lag;
        n_o_last   = r_o_last;
        n_o_lost   = r_o_lost;
        we         = 1'b0;

        case (r_state)
            S_IDLE: begin
                // Unlabelled events are taken and dropped without touching state.
                if (s_accept && in_lab != '0) begin
                    n_t_new = i_s_tdata[TIME_W-1:0];
                    n_k_new = in_lab;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_state = (r_count == '0) ? S_STORE : S_EVRD;
                end
            end
            S_EVRD: begin
                n_state = S_EVCK;
            end
            S_EVCK: begin
                if (!dres.in_range) begin
                    n_head  = head_inc;
                    n_count = r_count - CW'(1);
                    n_state = (r_count == CW'(1)) ? S_STORE : S_EVRD;
                end else begin
                    n_state = S_SCRD;
                end
            end
            S_SCRD: begin
                n_state = S_SCCK;
            end
            S_SCCK: begin
                n_cand_lab = rd_lab;
                n_cand_d   = dres.diff[LAG_W-1:0];
                if (dres.in_range) begin
                    n_state = r_pend ? S_EMA : S_EMB;
                end else if (scan_done) begin
                    // Out-of-order times may leave later entries out of range.
                    n_state = r_pend ? S_FIN : S_STORE;
                end else begin
                    n_idx   = idx_inc;
                    n_state = S_SCRD;
                end
            end
            S_EMA: begin
                if (ofree) begin
                    n_ov       = 1'b1;
                    n_o_first  = LABEL_W'(r_k_new);
                    n_o_second = LABEL_W'(r_pend_lab);
                    n_o_lag    = LAG_W'(0) - r_pend_d;
                    n_o_last   = 1'b0;
                    n_o_lost   = r_ovf;
                    n_state    = S_EMB;
                end
            end
            S_EMB: begin
                if (ofree) begin
                    n_ov       = 1'b1;
                    n_o_first  = LABEL_W'(r_cand_lab);
                    n_o_second = LABEL_W'(r_k_new);
                    n_o_lag    = r_cand_d;
                    n_o_last   = 1'b0;
                    n_o_lost   = r_ovf;
                    n_pend     = 1'b1;
                    n_pend_lab = r_cand_lab;
                    n_pend_d   = r_cand_d;
                    if (scan_done) begin
                        n_state = S_FIN;
                    end else begin
                        n_idx   = idx_inc;
                        n_state = S_SCRD;
                    end
                end
            end
            S_FIN: begin
                if (ofree) begin
                    n_ov       = 1'b1;
                    n_o_first  = LABEL_W'(r_k_new);
                    n_o_second = LABEL_W'(r_pend_lab);
                    n_o_lag    = LAG_W'(0) - r_pend_d;
                    n_o_last   = 1'b1;
                    n_o_lost   = r_ovf;
                    n_pend     = 1'b0;
                    n_state    = S_STORE;
                end
            end
            S_STORE: begin
                // A full window overwrites its oldest entry and raises the sticky flag.
                we = 1'b1;
                if (full) begin
                    n_head = head_inc;
                    n_ovf  = 1'b1;
                end else begin
                    n_count = r_count + CW'(1);
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_idx   <= '0;
            r_ovf   <= 1'b0;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_ovf   <= n_ovf;
            r_pend  <= n_pend;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t_new    <= n_t_new;
        r_k_new    <= n_k_new;
        r_pend_lab <= n_pend_lab;
        r_pend_d   <= n_pend_d;
        r_cand_lab <= n_cand_lab;
        r_cand_d   <= n_cand_d;
        r_o_first  <= n_o_first;
        r_o_second <= n_o_second;
        r_o_lag    <= n_o_lag;
        r_o_last   <= n_o_last;
        r_o_lost   <= n_o_lost;
    end

    // ---------------------------------------------------------------- outputs
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = M_TDATA_W'({r_o_lag, r_o_second, r_o_first});
    assign o_m_tlast  = r_o_last;
    assign o_m_tuser  = r_o_lost;

    // ---------------------------------------------------------------- checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("window count exceeds depth");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |=> r_ovf)
        else $error("overflow flag cleared without reset");

    a_idle_beat_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_ov) |-> r_o_last)
        else $error("beat waiting in idle is not the last of its event");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && in_lab != '0) |=> !o_s_tready)
        else $error("labelled event accepted but block not busy");

endmodule

// File: tb/sv/wepl_pair_watch.sv
// Monitor that predicts the pair stream from accepted events and compares every result beat.
module wepl_pair_watch (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [wepl_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [wepl_pkg::M_TDATA_W-1:0] i_m_tdata,
    input  logic                           i_m_tlast,
    input  logic                           i_m_tuser,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [wepl_pkg::APB_AW-1:0]    i_paddr,
    input  logic [wepl_pkg::APB_DW-1:0]    i_pwdata,
    input  logic                           i_pready,
    output int                             o_mismatches,
    output int                             o_pairs_pending
);
    import wepl_pkg::*;

    localparam int DEPTH = WINDOW_DEPTH_DEF;
    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [LABEL_W-1:0] LABEL_MASK = LABEL_W'((1 << LABEL_BITS_DEF) - 1);

    typedef struct packed {
        logic [LABEL_W-1:0] first_label;
        logic [LABEL_W-1:0] second_label;
        logic [LAG_W-1:0]   lag;
        logic               last_pair;
        logic               pairs_lost;
    } t_lag_pair;

    logic [TIME_W-1:0]    win_time  [DEPTH];
    logic [LABEL_W-1:0]   win_label [DEPTH];
    logic [IDX_W-1:0]     win_head;
    logic [IDX_W:0]       win_count;
    logic                 overflow_seen;
    logic [MAX_LAG_W-1:0] max_lag;
    t_lag_pair            predicted_pairs[$];
    int                   mismatch_total = 0;
    int                   pairs_waiting  = 0;

    assign o_mismatches    = mismatch_total;
    assign o_pairs_pending = pairs_waiting;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("pair check: %s: got %0d, wanted %0d", what, got, want);
        mismatch_total++;
    endtask

    task automatic derive_pairs(input logic [TIME_W-1:0] t_new, input logic [LABEL_W-1:0] lab_in);
        logic [LABEL_W-1:0] lab;
        logic [TIME_W-1:0]  d;
        logic [IDX_W-1:0]   pos;
        t_lag_pair          pr;
        int                 hits;
        int                 seen;
        int                 i;
        lab = lab_in & LABEL_MASK;
        if (lab == '0) begin
            return;
        end
        // Entries out of range at the old end are retired for good.
        while (win_count != 0 && (t_new - win_time[win_head]) > TIME_W'(max_lag)) begin
            win_head  = win_head + IDX_W'(1);
            win_count = win_count - (IDX_W + 1)'(1);
        end
        // Out-of-range entries further in (time went backwards) are skipped, not retired.
        hits = 0;
        for (i = 0; i < int'(win_count); i++) begin
            pos = win_head + IDX_W'(i);
            if ((t_new - win_time[pos]) <= TIME_W'(max_lag)) begin
                hits++;
            end
        end
        seen = 0;
        for (i = 0; i < int'(win_count); i++) begin
            pos = win_head + IDX_W'(i);
            d   = t_new - win_time[pos];
            if (d <= TIME_W'(max_lag)) begin
                seen++;
                pr.first_label  = win_label[pos];
                pr.second_label = lab;
                pr.lag          = d[LAG_W-1:0];
                pr.last_pair    = 1'b0;
                pr.pairs_lost   = overflow_seen;
                predicted_pairs.push_back(pr);
                pr.first_label  = lab;
                pr.second_label = win_label[pos];
                pr.lag          = LAG_W'(0) - d[LAG_W-1:0];
                pr.last_pair    = (seen == hits);
                predicted_pairs.push_back(pr);
            end
        end
        if (win_count == (IDX_W + 1)'(DEPTH)) begin
            pos           = win_head;
            win_head      = win_head + IDX_W'(1);
            overflow_seen = 1'b1;
        end else begin
            pos       = win_head + win_count[IDX_W-1:0];
            win_count = win_count + (IDX_W + 1)'(1);
        end
        win_time[pos]  = t_new;
        win_label[pos] = lab;
    endtask

    task automatic check_pair(input logic [M_TDATA_W-1:0] data, input logic last, input logic lost);
        t_lag_pair want;
        if (predicted_pairs.size() == 0) begin
            report_mismatch("pair beat with nothing predicted, lag",
                            longint'(data[16 +: LAG_W]), longint'(-1));
            return;
        end
        want = predicted_pairs.pop_front();
        if (data[7:0] != want.first_label) begin
            report_mismatch("first_label", longint'(data[7:0]), longint'(want.first_label));
        end
        if (data[15:8] != want.second_label) begin
            report_mismatch("second_label", longint'(data[15:8]),
                            longint'(want.second_label));
        end
        if (data[16 +: LAG_W] != want.lag) begin
            report_mismatch("lag", longint'(data[16 +: LAG_W]), longint'(want.lag));
        end
        if (data[M_TDATA_W-1:16+LAG_W] != '0) begin
            report_mismatch("tdata padding", longint'(data[M_TDATA_W-1:16+LAG_W]),
                            longint'(0));
        end
        if (last != want.last_pair) begin
            report_mismatch("last_pair", longint'(last), longint'(want.last_pair));
        end
        if (lost != want.pairs_lost) begin
            report_mismatch("pairs_lost", longint'(lost), longint'(want.pairs_lost));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            win_head      = '0;
            win_count     = '0;
            overflow_seen = 1'b0;
            max_lag       = MAX_LAG_RESET;
            predicted_pairs.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr[APB_AW-1:2] == REG_MAX_LAG) begin
                max_lag = i_pwdata[MAX_LAG_W-1:0];
            end
            if (i_s_tvalid && i_s_tready) begin
                derive_pairs(i_s_tdata[TIME_W-1:0], i_s_tdata[TIME_W +: LABEL_W]);
            end
            if (i_m_tvalid && i_m_tready) begin
                check_pair(i_m_tdata, i_m_tlast, i_m_tuser);
            end
        end
        pairs_waiting = predicted_pairs.size();
    end

endmodule

// File: tb/sv/testbench.sv
// Testbench top for the pair lag block: clock, reset, event and register stimulus, verdict.
module testbench;
    import wepl_pkg::*;

    // The limit stays far above what a few hundred items need, even with a short
    // receiver stall on every result beat.
    localparam int CYCLE_LIMIT   = 600000;
    localparam int HOLD_CYCLES   = 700;
    // An event that yields no pair can still keep the block busy scanning its
    // window, so every register write waits this long after the last pair.
    localparam int SETTLE_CYCLES = 200;
    localparam int PHASE_ITEMS   = 46;
    localparam logic [APB_AW-1:0] ADDR_MAX_LAG = {REG_MAX_LAG, 2'b00};

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata  = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic                 o_m_tlast;
    logic                 o_m_tuser;
    logic                 psel       = 1'b0;
    logic                 penable    = 1'b0;
    logic                 pwrite     = 1'b0;
    logic [APB_AW-1:0]    paddr      = '0;
    logic [APB_DW-1:0]    pwdata     = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    int                   mismatch_count;
    int                   pairs_pending;
    int                   cycle_count = 0;

    // Stimulus state: the running event clock and the lag range currently loaded.
    logic [TIME_W-1:0]    now_t = '0;
    int unsigned          cur_max_lag = 32'(MAX_LAG_RESET);
    bit                   hold_req   = 1'b0;
    bit                   hold_done  = 1'b0;
    bit                   tail_quiet = 1'b0;

    always #10 i_clk = ~i_clk;

    windowed_event_pair_lags dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    wepl_pair_watch pair_watch (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (i_s_tvalid),
        .i_s_tready      (o_s_tready),
        .i_s_tdata       (i_s_tdata),
        .i_m_tvalid      (o_m_tvalid),
        .i_m_tready      (i_m_tready),
        .i_m_tdata       (o_m_tdata),
        .i_m_tlast       (o_m_tlast),
        .i_m_tuser       (o_m_tuser),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_pready        (pready),
        .o_mismatches    (mismatch_count),
        .o_pairs_pending (pairs_pending)
    );

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("windowed_event_pair_lags: mismatch");
            $finish;
        end
    end

    // Result side. Short random stalls alternate with ready runs; once during the
    // run the receiver holds off for a long stretch so that the block backs up and
    // drops tready on the event side. In the quiet tail the receiver is always
    // ready.
    initial begin : pair_receiver
        forever begin
            if (hold_req && !hold_done) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (!tail_quiet && $urandom_range(0, 3) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // Offers one event beat and waits for the edge that accepts it, then for any source gap.
    // tvalid is left high otherwise, so that back-to-back beats never lower and raise it in one step.
    task automatic offer_event(input logic [TIME_W-1:0] t, input logic [LABEL_W-1:0] lab);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {lab, t};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        // Random source gap, none in the quiet tail.
        if (!tail_quiet && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Waits until every predicted pair has come out, then lets the block finish any
    // scan that produces no beat. The pending count is sampled on the falling edge,
    // away from the edge at which the monitor updates it.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        do @(negedge i_clk); while (pairs_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write: a setup phase, then an access phase. Upper data bits are random
    // since only the low 16 bits belong to the register.
    task automatic write_max_lag(input logic [MAX_LAG_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MAX_LAG;
        pwdata  <= {16'($urandom), v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_max_lag = 32'(v);
    endtask

    // Mostly well-formed traffic: non-decreasing times, steps short against the lag
    // range so the window fills and overflows. A few beats jump past the range,
    // step backwards or land anywhere, and about one in ten carries label zero.
    task automatic random_events(input int count);
        int k;
        int roll;
        logic [LABEL_W-1:0] lab;
        for (k = 0; k < count; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
                now_t = now_t - $urandom_range(1, 3000);
            end else if (roll < 9) begin
                now_t = now_t + cur_max_lag + $urandom_range(1, 5000);
            end else if (roll < 11) begin
                now_t = $urandom;
            end else begin
                now_t = now_t + $urandom_range(0, cur_max_lag / 64 + 1);
            end
            if ($urandom_range(0, 9) == 0) begin
                lab = '0;
            end else begin
                lab = LABEL_W'($urandom_range(1, 255));
            end
            offer_event(now_t, lab);
        end
    endtask

    initial begin : stimulus
        int unsigned phase_lag [6];
        int ph;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset lag range of 1500. Unlabelled events, an
        // empty window, a pair at exactly the range limit, eviction at the old end,
        // equal times, a jump that clears the window, time wrapping past zero, and
        // a backwards step that skips a newer entry without retiring it.
        offer_event(32'd0, 8'd0);
        offer_event(32'd0, 8'd1);
        offer_event(32'd1500, 8'd255);
        offer_event(32'd1501, 8'd7);
        offer_event(32'd1501, 8'd0);
        offer_event(32'd1501, 8'd3);
        offer_event(32'hFFFF_FFF0, 8'h80);
        offer_event(32'd5, 8'h55);
        offer_event(32'd3, 8'hAA);

        // Zero lag range: only events at the very same time pair up.
        settle();
        write_max_lag(16'd0);
        offer_event(32'd100, 8'd1);
        offer_event(32'd100, 8'd2);
        offer_event(32'd100, 8'd3);
        offer_event(32'd101, 8'd4);

        // Widest range: a lag of exactly 65535 and its mirror, then one beyond it,
        // then the top timestamp twice.
        settle();
        write_max_lag(16'hFFFF);
        offer_event(32'd200000, 8'd9);
        offer_event(32'd265535, 8'd10);
        offer_event(32'd265536, 8'd11);
        offer_event(32'hFFFF_FFFF, 8'hFF);
        offer_event(32'hFFFF_FFFF, 8'h01);

        // Random phases, each under its own lag range. The long receiver hold-off
        // falls into the first phase; the last phase runs without any idling.
        phase_lag[0] = 65535;
        phase_lag[1] = $urandom_range(1, 400);
        phase_lag[2] = 0;
        phase_lag[3] = $urandom_range(401, 65534);
        phase_lag[4] = 3000;
        phase_lag[5] = 32'(MAX_LAG_RESET);
        now_t = $urandom;
        for (ph = 0; ph < 6; ph++) begin
            settle();
            write_max_lag(MAX_LAG_W'(phase_lag[ph]));
            if (ph == 0) begin
                hold_req <= 1'b1;
            end
            if (ph == 5) begin
                tail_quiet = 1'b1;
            end
            random_events(PHASE_ITEMS);
        end

        settle();
        if (mismatch_count == 0) begin
            $display("windowed_event_pair_lags: match");
        end else begin
            $display("windowed_event_pair_lags: mismatch");
        end
        $finish;
    end

endmodule

// File: windowed_event_pair_lags.f
design/wepl_pkg.sv
design/wepl_cfg.sv
design/wepl_window.sv
design/wepl_diff.sv
design/windowed_event_pair_lags.sv
tb/sv/wepl_pair_watch.sv
tb/sv/testbench.sv
